@@ sv/lbc_pkg.sv @@
// Package for the block cache: payload structs, controller states and the
// command and status groups between controller and datapath. No dependencies.
package lbc_pkg;

  localparam int LBC_LINES = 64;
  localparam int LBC_WORDS_PER_BLOCK = 32;
  localparam logic [6:0] LBC_ENTRIES_RESET = 7'd64;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  device_num;
    logic [15:0] sector;
    logic [15:0] block_number;
    logic [63:0] data_word;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] data_word_res;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_GRD,
    ST_GLD,
    ST_GWAIT,
    ST_MWAIT
  } state_t;

  typedef struct packed {
    logic start;       // latch request, start the line scan
    logic put_word;    // store a follow-on word of an open put
    logic put_commit;  // claim the chosen line and store the first word
    logic rd_word;     // read one block word of the hit line
    logic load_word;   // move that word into the output register
    logic load_miss;   // load the miss beat into the output register
    logic next_word;   // advance the block word counter
  } cmd_t;

  typedef struct packed {
    logic put_active;
    logic scan_done;
    logic req_put;
    logic hit;
    logic word_last;
    logic out_taken;
  } sts_t;

endpackage

@@ sv/lbc_ctrl.sv @@
// Controller for the block cache: sequences scan, put commit and get output.
// Depends on lbc_pkg.
module lbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  input  lbc_pkg::sts_t sts,
  output lbc_pkg::cmd_t cmd
);
  import lbc_pkg::*;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !(in_op == OP_PUT && sts.put_active)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (sts.req_put) state_nxt = ST_IDLE;
        else if (sts.hit)         state_nxt = ST_GRD;
        else                      state_nxt = ST_MWAIT;
      end
      ST_GRD:  state_nxt = ST_GLD;
      ST_GLD:  state_nxt = ST_GWAIT;
      ST_GWAIT: begin
        if (sts.out_taken) state_nxt = sts.word_last ? ST_IDLE : ST_GRD;
      end
      ST_MWAIT: begin
        if (sts.out_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_PUT && sts.put_active) cmd.put_word = 1'b1;
          else                                   cmd.start = 1'b1;
        end
      end
      ST_DECIDE: begin
        priority if (sts.req_put) cmd.put_commit = 1'b1;
        else if (!sts.hit)        cmd.load_miss = 1'b1;
      end
      ST_GRD: cmd.rd_word = 1'b1;
      ST_GLD: cmd.load_word = 1'b1;
      ST_GWAIT: begin
        if (sts.out_taken && !sts.word_last) cmd.next_word = 1'b1;
      end
      ST_SCAN, ST_MWAIT: ;
      default: ;
    endcase
  end

endmodule

@@ sv/lbc_dp.sv @@
// Datapath for the block cache: tag and stamp memory, valid bits, block data
// memory, line scan and output register. Depends on lbc_pkg.
module lbc_dp #(
  parameter int LINES = lbc_pkg::LBC_LINES,
  parameter int WORDS_PER_BLOCK = lbc_pkg::LBC_WORDS_PER_BLOCK
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lbc_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  output logic          out_valid,
  input  logic          out_stall,
  output lbc_pkg::out_t out_data,
  input  lbc_pkg::cmd_t cmd,
  output lbc_pkg::sts_t sts
);
  import lbc_pkg::*;

  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int NW = $clog2(LINES + 1);
  localparam int WW = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int DEPTH = LINES * (2 ** WW);
  localparam logic [WW-1:0] WORD_LAST = WW'(WORDS_PER_BLOCK - 1);

  typedef struct packed {
    logic [7:0]  dev;
    logic [15:0] sec;
    logic [15:0] blk;
    logic [31:0] stamp;
  } tag_t;

  tag_t        tag_mem [LINES];
  logic [63:0] data_mem [DEPTH];

  logic [6:0]    entries_r;
  logic [LINES-1:0] valid_r;
  logic [31:0]   stamp_cnt_r;
  logic          put_active_r;
  logic [LW-1:0] put_line_r;
  logic [WW-1:0] put_cnt_r;

  logic          req_put_r;
  logic [7:0]    req_dev_r;
  logic [15:0]   req_sec_r;
  logic [15:0]   req_blk_r;
  logic [63:0]   req_word_r;

  logic          scan_on_r;
  logic [NW-1:0] iss_idx_r;
  logic          cmp_en_r;
  logic [LW-1:0] cmp_idx_r;
  tag_t          tag_q_r;
  logic          hit_r, inv_found_r, min_found_r;
  logic [LW-1:0] hit_idx_r, inv_idx_r, min_idx_r;
  logic [31:0]   min_stamp_r;

  logic [WW-1:0] word_cnt_r;
  logic [63:0]   data_q_r;
  logic          out_valid_r;
  out_t          out_r;

  logic [NW-1:0] n_lines;
  logic          issue;
  logic          scan_done;
  logic          out_taken;
  logic          line_v;
  logic          key_eq;
  logic [LW-1:0] line_sel;
  logic          dwe;
  logic [LW+WW-1:0] dwaddr;
  logic [63:0]   dwdata;

  // Zero entries act as one; anything past the built size acts as the size.
  always_comb begin
    priority if (entries_r == 7'd0)      n_lines = NW'(1);
    else if (32'(entries_r) > LINES)    n_lines = NW'(LINES);
    else                                n_lines = NW'(entries_r);
  end

  assign issue     = scan_on_r && (iss_idx_r < n_lines);
  assign scan_done = scan_on_r && !issue && !cmp_en_r;
  assign out_taken = out_valid_r && !out_stall;
  assign line_v    = valid_r[cmp_idx_r];
  assign key_eq    = (tag_q_r.dev == req_dev_r) && (tag_q_r.sec == req_sec_r) &&
                     (tag_q_r.blk == req_blk_r);
  assign line_sel  = hit_r ? hit_idx_r : (inv_found_r ? inv_idx_r : min_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r    <= LBC_ENTRIES_RESET;
      valid_r      <= '0;
      stamp_cnt_r  <= '0;
      put_active_r <= 1'b0;
      put_cnt_r    <= '0;
      scan_on_r    <= 1'b0;
      cmp_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) entries_r <= cfg_wdata;
      if (cmd.start) scan_on_r <= 1'b1;
      else if (scan_done) scan_on_r <= 1'b0;
      cmp_en_r <= issue;
      if (cmd.put_commit) begin
        stamp_cnt_r <= stamp_cnt_r + 32'd1;
        valid_r[line_sel] <= (WORDS_PER_BLOCK == 1);
        put_active_r <= (WORDS_PER_BLOCK != 1);
        put_cnt_r <= (WORDS_PER_BLOCK == 1) ? '0 : WW'(1);
      end else if (cmd.put_word) begin
        if (put_cnt_r == WORD_LAST) begin
          valid_r[put_line_r] <= 1'b1;
          put_active_r <= 1'b0;
          put_cnt_r <= '0;
        end else begin
          put_cnt_r <= put_cnt_r + WW'(1);
        end
      end
      if (cmd.load_word || cmd.load_miss) out_valid_r <= 1'b1;
      else if (out_taken) out_valid_r <= 1'b0;
    end
  end

  // Scan state and request latch; the match and victim trackers compare the
  // registered tag read in the cycle after it is issued.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_put_r   <= in_data.op;
      req_dev_r   <= in_data.device_num;
      req_sec_r   <= in_data.sector;
      req_blk_r   <= in_data.block_number;
      req_word_r  <= in_data.data_word;
      iss_idx_r   <= '0;
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
      min_found_r <= 1'b0;
      word_cnt_r  <= '0;
    end else begin
      if (issue) iss_idx_r <= iss_idx_r + NW'(1);
      if (cmd.next_word) word_cnt_r <= word_cnt_r + WW'(1);
    end
    if (issue) begin
      tag_q_r   <= tag_mem[iss_idx_r[LW-1:0]];
      cmp_idx_r <= iss_idx_r[LW-1:0];
    end
    if (cmd.put_commit) begin
      tag_mem[line_sel] <= '{dev: req_dev_r, sec: req_sec_r, blk: req_blk_r,
                             stamp: stamp_cnt_r};
      put_line_r <= line_sel;
    end
    if (cmp_en_r && !cmd.start) begin
      if (line_v && key_eq && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (!line_v && !inv_found_r) begin
        inv_found_r <= 1'b1;
        inv_idx_r   <= cmp_idx_r;
      end
      if (line_v && (!min_found_r || tag_q_r.stamp < min_stamp_r)) begin
        min_found_r <= 1'b1;
        min_stamp_r <= tag_q_r.stamp;
        min_idx_r   <= cmp_idx_r;
      end
    end
  end

  assign dwe    = cmd.put_commit || cmd.put_word;
  assign dwaddr = cmd.put_commit ? {line_sel, WW'(0)} : {put_line_r, put_cnt_r};
  assign dwdata = cmd.put_commit ? req_word_r : in_data.data_word;

  always_ff @(posedge clk) begin
    if (dwe) data_mem[dwaddr] <= dwdata;
    if (cmd.rd_word) data_q_r <= data_mem[{hit_idx_r, word_cnt_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      out_r <= '{hit: 1'b1, data_word_res: data_q_r, last: (word_cnt_r == WORD_LAST)};
    end else if (cmd.load_miss) begin
      out_r <= '{hit: 1'b0, data_word_res: 64'd0, last: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.put_active = put_active_r;
  assign sts.scan_done  = scan_done;
  assign sts.req_put    = req_put_r;
  assign sts.hit        = hit_r;
  assign sts.word_last  = (word_cnt_r == WORD_LAST);
  assign sts.out_taken  = out_taken;

  a_commit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_commit |-> !put_active_r)
    else $error("put committed while another put is open");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_word || cmd.load_miss) |-> !out_valid_r)
    else $error("output register loaded while a beat is pending");

  a_word_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_word |-> (hit_r && !scan_on_r))
    else $error("block word read without a completed hit");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_on_r |-> (iss_idx_r <= n_lines))
    else $error("scan index ran past the lines in use");

endmodule

@@ sv/lru_block_cache.sv @@
// Top level of the fully associative block cache with write-stamp replacement.
// Depends on lbc_pkg, lbc_ctrl and lbc_dp.
//
// A get scans the n lines in use (entries_r, clamped to 1..LINES) one per
// cycle through the tag memory read port before the answer; a miss then gives
// one beat, a hit gives WORDS_PER_BLOCK beats, each read through the registered
// read of the block data memory into the output register and held by any output
// stall. The first word of a put takes the same scan and then claims a line;
// each following word of the put is taken as it arrives, without a scan. Input is
// stalled while a scan runs or a get result is being delivered.
module lru_block_cache #(
  parameter int LINES = lbc_pkg::LBC_LINES,
  parameter int WORDS_PER_BLOCK = lbc_pkg::LBC_WORDS_PER_BLOCK
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lbc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lbc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata
);
  import lbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbc_dp #(
    .LINES           (LINES),
    .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
